// ===== hdl/csrmv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the CSR sparse matrix-vector unit.
// No dependencies; imported by the front, back and top-level modules.
package csrmv_pkg;

    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 64;
    localparam int PROD_FRAC = 16;

    // Input item kinds as they arrive on tuser
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_NONZERO = 2'd1;
    localparam logic [1:0] ACT_EMPTY   = 2'd2;

    // Queue depth between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    localparam logic signed [VAL_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] SUM_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_MAC   = 2'd1,
        OP_EMPTY = 2'd2
    } t_op;

    // One classified item waiting for the back end
    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        idx;
        logic                    in_range;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_qent;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qhead;

endpackage

// ===== hdl/csrmv_front.sv =====
`timescale 1ns / 1ps
// Front end: accept items, classify them and queue them for the back end.
// Depends on csrmv_pkg.
module csrmv_front #(
    parameter int VECTOR_LENGTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_action,
    input  logic [csrmv_pkg::IDX_W-1:0]   i_index,
    input  logic [csrmv_pkg::VAL_W-1:0]   i_value,
    input  logic                          i_last,
    output csrmv_pkg::t_qhead             o_head,
    input  logic                          i_pop
);
    import csrmv_pkg::*;

    t_qent              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic [Q_PTR_W:0]   n_count;

    t_qent w_ent;
    logic  w_keep;
    logic  w_in_range;
    logic  w_push;
    logic  w_pop;

    assign w_in_range = (32'(i_index) < 32'(VECTOR_LENGTH));

    always_comb begin
        w_ent.idx      = i_index;
        w_ent.in_range = w_in_range;
        w_ent.value    = i_value;
        w_ent.last     = i_last;
        case (i_action)
            ACT_LOAD: begin
                // drop loads past the end of the store
                w_ent.op = OP_LOAD;
                w_keep   = w_in_range;
            end
            ACT_NONZERO: begin
                w_ent.op = OP_MAC;
                w_keep   = 1'b1;
            end
            ACT_EMPTY: begin
                w_ent.op = OP_EMPTY;
                w_keep   = 1'b1;
            end
            default: begin
                w_ent.op = OP_LOAD;
                w_keep   = 1'b0;
            end
        endcase
    end

    assign o_ready = (r_count != (Q_PTR_W+1)'(Q_DEPTH));
    assign w_push  = i_valid && o_ready && w_keep;
    assign w_pop   = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_ent;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.ent   = r_q[r_rd_ptr];

endmodule

// ===== hdl/csrmv_back.sv =====
`timescale 1ns / 1ps
// Back end: vector store, multiplier, row accumulator and output register.
// Depends on csrmv_pkg.
module csrmv_back #(
    parameter int VECTOR_LENGTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csrmv_pkg::t_qhead             i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [csrmv_pkg::VAL_W-1:0]   o_sum,
    output logic [csrmv_pkg::IDX_W-1:0]   o_row,
    output logic                          o_sat
);
    import csrmv_pkg::*;

    localparam int DEPTH = (VECTOR_LENGTH < (1 << IDX_W)) ? VECTOR_LENGTH : (1 << IDX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VAL_W-1:0] r_store [DEPTH];

    logic w_en;
    logic w_pop;
    logic [AW-1:0] w_addr;

    // stage 1: store access
    logic                    r_s1_valid;
    t_op                     r_s1_op;
    logic signed [VAL_W-1:0] r_s1_val;
    logic                    r_s1_last;
    logic                    r_s1_inr;
    logic [VAL_W-1:0]        r_elem;

    // stage 2: product
    logic                    r_s2_valid;
    t_op                     r_s2_op;
    logic                    r_s2_last;
    logic signed [ACC_W-1:0] r_s2_prod;

    // stage 3: finished row sum
    logic                    r_s3_valid;
    logic signed [ACC_W-1:0] r_s3_sum;
    logic [IDX_W-1:0]        r_s3_row;

    logic signed [ACC_W-1:0] r_acc;
    logic [IDX_W-1:0]        r_row;

    logic signed [ACC_W-1:0] w_term;
    logic signed [ACC_W-1:0] w_raw;
    logic signed [ACC_W-1:0] w_next_acc;
    logic signed [VAL_W-1:0] w_elem;

    logic                    r_out_valid;
    logic [VAL_W-1:0]        r_out_sum;
    logic [IDX_W-1:0]        r_out_row;
    logic                    r_out_sat;
    logic                    w_fits;

    // whole pipe holds while a result waits on the output
    assign w_en   = !(r_out_valid && !i_ready);
    assign w_pop  = w_en && i_head.valid;
    assign o_pop  = w_pop;
    assign w_addr = i_head.ent.idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_pop && (i_head.ent.op == OP_LOAD)) begin
            r_store[w_addr] <= i_head.ent.value;
        end
        if (w_en) begin
            r_elem <= r_store[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_op   <= i_head.ent.op;
            r_s1_val  <= i_head.ent.value;
            r_s1_last <= i_head.ent.last;
            r_s1_inr  <= i_head.ent.in_range;
        end
    end

    assign w_elem = r_s1_inr ? $signed(r_elem) : '0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_op   <= r_s1_op;
            r_s2_last <= r_s1_last;
            r_s2_prod <= r_s1_val * w_elem;
        end
    end

    // floor shift of the product, then add clipped at the 64-bit limits
    assign w_term = r_s2_prod >>> PROD_FRAC;
    assign w_raw  = r_acc + w_term;

    always_comb begin
        w_next_acc = w_raw;
        if ((r_acc[ACC_W-1] == w_term[ACC_W-1]) && (w_raw[ACC_W-1] != r_acc[ACC_W-1])) begin
            w_next_acc = r_acc[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_acc      <= '0;
            r_row      <= '0;
        end else if (w_en) begin
            r_s1_valid <= w_pop;
            r_s2_valid <= r_s1_valid && (r_s1_op != OP_LOAD);
            r_s3_valid <= 1'b0;
            if (r_s2_valid) begin
                case (r_s2_op)
                    OP_MAC: begin
                        if (r_s2_last) begin
                            r_acc      <= '0;
                            r_s3_valid <= 1'b1;
                            r_row      <= r_row + 1'b1;
                        end else begin
                            r_acc <= w_next_acc;
                        end
                    end
                    OP_EMPTY: begin
                        r_acc      <= '0;
                        r_s3_valid <= 1'b1;
                        r_row      <= r_row + 1'b1;
                    end
                    default: begin
                        r_acc <= r_acc;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_sum <= (r_s2_op == OP_MAC) ? w_next_acc : '0;
            r_s3_row <= r_row;
        end
    end

    // row sum fits when the top 33 bits agree
    assign w_fits = (r_s3_sum[ACC_W-1:VAL_W-1] == '0)
                 || (r_s3_sum[ACC_W-1:VAL_W-1] == '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_row <= r_s3_row;
            r_out_sat <= !w_fits;
            if (w_fits) begin
                r_out_sum <= r_s3_sum[VAL_W-1:0];
            end else begin
                r_out_sum <= r_s3_sum[ACC_W-1] ? SUM_MIN : SUM_MAX;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_sum   = r_out_sum;
    assign o_row   = r_out_row;
    assign o_sat   = r_out_sat;

endmodule

// ===== hdl/csr_sparse_matvec_unit.sv =====
`timescale 1ns / 1ps
// CSR sparse matrix-vector unit: top level, front queue plus back pipeline.
// A result reaches m_axis from the item that ends its row through the queue and the stage 1, 2, 3 and output registers.
// Throughput: one item per cycle; the back pipeline only holds while the output stalls.
// Reset (i_rst_n low, synchronous) empties the queue, clears the row sum and row number;
// the vector store is not cleared and holds garbage until loaded.
// Depends on csrmv_pkg, csrmv_front, csrmv_back.
module csr_sparse_matvec_unit #(
    parameter int VECTOR_LENGTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [9:0] index, [41:10] value, [47:42] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    input  logic        s_axis_tlast,   // row end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] row_sum, [41:32] row_number, [47:42] zero
    output logic [0:0]  m_axis_tuser    // [0] saturated
);
    import csrmv_pkg::*;

    t_qhead             w_head;
    logic               w_pop;
    logic [VAL_W-1:0]   w_sum;
    logic [IDX_W-1:0]   w_row;
    logic               w_sat;

    // Front: take items, drop action 3 and out-of-range loads, queue the rest.
    csrmv_front #(
        .VECTOR_LENGTH (VECTOR_LENGTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_action (s_axis_tuser),
        .i_index  (s_axis_tdata[IDX_W-1:0]),
        .i_value  (s_axis_tdata[IDX_W+VAL_W-1:IDX_W]),
        .i_last   (s_axis_tlast),
        .o_head   (w_head),
        .i_pop    (w_pop)
    );

    // Back: store access, multiply, accumulate, clip and hold the result.
    csrmv_back #(
        .VECTOR_LENGTH (VECTOR_LENGTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_sum   (w_sum),
        .o_row   (w_row),
        .o_sat   (w_sat)
    );

    // Pack result fields, pad with zeros to whole bytes
    assign m_axis_tdata = {6'd0, w_row, w_sum};
    assign m_axis_tuser = w_sat;

endmodule

// ===== hdl/csrmv_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the CSR sparse matrix-vector unit, bound to the top level.
// Depends on csr_sparse_matvec_unit.
module csrmv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);
    logic [9:0] r_exp_row;

    // track the row number the next result must carry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_row <= '0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_exp_row <= m_axis_tdata[41:32] + 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[31:0] == 32'h7FFF_FFFF) || (m_axis_tdata[31:0] == 32'h8000_0000))
        else $error("saturated flag without a clipped sum");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[41:32] == r_exp_row)
        else $error("row number out of sequence");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:42] == 6'd0)
        else $error("padding bits set");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind csr_sparse_matvec_unit csrmv_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
